FILE: hw/rtl/adjacency_matrix_edge_scanner_core_assert.svh
// Assertion macros used by the checker of this block.
`ifndef ADJACENCY_MATRIX_EDGE_SCANNER_CORE_ASSERT_SVH
`define ADJACENCY_MATRIX_EDGE_SCANNER_CORE_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define AMESC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define AMESC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

FILE: hw/rtl/amesc_pkg.sv
package amesc_pkg;

    localparam int OP_W           = 3;
    localparam int VID_W          = 4;
    localparam int WGT_W          = 32;
    localparam int VCNT_W         = 5;
    localparam int DEF_MAX_VERTEX = 16;

    localparam logic [VCNT_W-1:0] VCNT_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_SET      = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
    localparam logic [OP_W-1:0] OP_SCAN_ALL = 3'd2;
    localparam logic [OP_W-1:0] OP_SCAN_SRC = 3'd3;
    localparam logic [OP_W-1:0] OP_NEXT     = 3'd4;
    localparam logic [OP_W-1:0] OP_READ     = 3'd5;

    typedef struct packed {
        logic                    found;
        logic [VID_W-1:0]        edge_src;
        logic [VID_W-1:0]        edge_dst;
        logic signed [WGT_W-1:0] edge_weight;
        logic                    ignored;
    } t_result;

endpackage

FILE: hw/rtl/adjacency_matrix_edge_scanner_core.sv
// Adjacency matrix edge scanner.
// Holds a MAX_VERTEX x MAX_VERTEX matrix of signed Q16.16 weights, zero meaning
// no edge. Commands enter on i_start/i_op/i_src/i_dst/i_weight and are taken
// when i_start is high and o_busy is low. Every command returns one result
// beat on o_valid with o_found, o_edge_src, o_edge_dst, o_edge_weight and
// o_ignored; the beat lasts one cycle and the receiver cannot stall it.
// Set, remove, scan starts and unknown codes return their beat the cycle after
// acceptance and never raise o_busy. Read holds o_busy while it goes through
// the registered port of the weight memory and the S_READ state. Next walks
// the matrix one entry per cycle, with a pause at each row boundary, from the
// scan cursor through the shared memory read port: a hit returns that entry
// and moves the cursor past it; once the live rows (or the source row) are
// used up, a beat with o_found low is returned and the scan ends.
// The vertex_count register sits at byte address 0 of the APB port and may
// only be written while the block is idle.
// After reset the weight memory is cleared one entry per cycle, and o_busy stays
// high until all MAX_VERTEX*MAX_VERTEX entries (256 at the default) are cleared;
// only then is the first command taken.
module adjacency_matrix_edge_scanner_core #(
    parameter int MAX_VERTEX = amesc_pkg::DEF_MAX_VERTEX
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [amesc_pkg::OP_W-1:0]         i_op,
    input  logic [amesc_pkg::VID_W-1:0]        i_src,
    input  logic [amesc_pkg::VID_W-1:0]        i_dst,
    input  logic signed [amesc_pkg::WGT_W-1:0] i_weight,
    output logic                               o_valid,
    output logic                               o_found,
    output logic [amesc_pkg::VID_W-1:0]        o_edge_src,
    output logic [amesc_pkg::VID_W-1:0]        o_edge_dst,
    output logic signed [amesc_pkg::WGT_W-1:0] o_edge_weight,
    output logic                               o_ignored,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    import amesc_pkg::*;

    localparam int DEPTH = MAX_VERTEX * MAX_VERTEX;
    localparam int AW    = $clog2(DEPTH);

    logic [VCNT_W-1:0] r_vcount;
    logic              w_sel_vcount;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WGT_W-1:0]  w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [WGT_W-1:0]  w_rdata;
    logic              w_res_valid;
    t_result           w_res;

    assign pready       = 1'b1;
    assign w_sel_vcount = (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCNT_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_vcount) begin
            r_vcount <= pwdata[VCNT_W-1:0];
        end
    end

    assign prdata = w_sel_vcount ? {{(32-VCNT_W){1'b0}}, r_vcount} : '0;

    amesc_ram #(
        .WIDTH (WGT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    amesc_ctrl #(
        .MAX_VERTEX (MAX_VERTEX)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_op        (i_op),
        .i_src       (i_src),
        .i_dst       (i_dst),
        .i_weight    (i_weight),
        .i_vcount    (r_vcount),
        .o_busy      (o_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    assign o_valid       = w_res_valid;
    assign o_found       = w_res.found;
    assign o_edge_src    = w_res.edge_src;
    assign o_edge_dst    = w_res.edge_dst;
    assign o_edge_weight = w_res.edge_weight;
    assign o_ignored     = w_res.ignored;

endmodule

FILE: hw/rtl/amesc_ram.sv
module amesc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/amesc_ctrl.sv
module amesc_ctrl #(
    parameter int MAX_VERTEX = amesc_pkg::DEF_MAX_VERTEX
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_start,
    input  logic [amesc_pkg::OP_W-1:0]                i_op,
    input  logic [amesc_pkg::VID_W-1:0]               i_src,
    input  logic [amesc_pkg::VID_W-1:0]               i_dst,
    input  logic signed [amesc_pkg::WGT_W-1:0]        i_weight,
    input  logic [amesc_pkg::VCNT_W-1:0]              i_vcount,
    output logic                                      o_busy,
    output logic                                      o_res_valid,
    output amesc_pkg::t_result                        o_res,
    output logic                                      o_we,
    output logic [$clog2(MAX_VERTEX*MAX_VERTEX)-1:0]  o_waddr,
    output logic [amesc_pkg::WGT_W-1:0]               o_wdata,
    output logic [$clog2(MAX_VERTEX*MAX_VERTEX)-1:0]  o_raddr,
    input  logic [amesc_pkg::WGT_W-1:0]               i_rdata
);

    import amesc_pkg::*;

    localparam int DEPTH = MAX_VERTEX * MAX_VERTEX;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = $clog2(MAX_VERTEX + 1);
    localparam int RW    = (VW > VID_W) ? VW : VID_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_READ  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic          r_active, n_active;
    logic          r_kind, n_kind;
    logic [RW-1:0] r_row, n_row;
    logic [VW-1:0] r_col, n_col;
    logic          r_pend, n_pend;
    logic [RW-1:0] r_prow, n_prow;
    logic [VW-1:0] r_pcol, n_pcol;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_res_valid, n_res_valid;
    t_result       r_res, n_res;

    logic [VW-1:0] w_n;
    logic [AW-1:0] w_addr_rc;
    logic [AW-1:0] w_addr_sd;
    logic          w_in_store;
    logic          w_hit;
    logic          w_exhausted;
    logic          w_wrap;

    always_comb begin
        if (i_vcount == '0) begin
            w_n = VW'(1);
        end else if (int'(i_vcount) > MAX_VERTEX) begin
            w_n = VW'(MAX_VERTEX);
        end else begin
            w_n = VW'(i_vcount);
        end
    end

    assign w_addr_rc   = AW'(r_row) * AW'(MAX_VERTEX) + AW'(r_col);
    assign w_addr_sd   = AW'(i_src) * AW'(MAX_VERTEX) + AW'(i_dst);
    assign w_in_store  = (int'(i_src) < MAX_VERTEX) && (int'(i_dst) < MAX_VERTEX);
    assign w_hit       = r_pend && (i_rdata != '0);
    assign w_exhausted = (r_row >= RW'(w_n)) || (r_kind && (r_col >= w_n));
    assign w_wrap      = !r_kind && (r_col >= w_n);

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_kind      = r_kind;
        n_row       = r_row;
        n_col       = r_col;
        n_pend      = r_pend;
        n_prow      = r_prow;
        n_pcol      = r_pcol;
        n_clr       = r_clr;
        n_res_valid = 1'b0;
        n_res       = '0;
        o_we        = 1'b0;
        o_waddr     = w_addr_sd;
        o_wdata     = '0;
        o_raddr     = w_addr_sd;

        unique case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_res_valid = 1'b1;
                    unique case (i_op)
                        OP_SET, OP_REMOVE: begin
                            if (r_active) begin
                                n_res.ignored = 1'b1;
                            end else if (w_in_store) begin
                                o_we    = 1'b1;
                                o_wdata = (i_op == OP_SET) ? i_weight : '0;
                            end
                        end
                        OP_SCAN_ALL: begin
                            n_active = 1'b1;
                            n_kind   = 1'b0;
                            n_row    = '0;
                            n_col    = '0;
                        end
                        OP_SCAN_SRC: begin
                            n_active = 1'b1;
                            n_kind   = 1'b1;
                            n_row    = RW'(i_src);
                            n_col    = '0;
                        end
                        OP_NEXT: begin
                            if (r_active) begin
                                n_res_valid = 1'b0;
                                n_pend      = 1'b0;
                                n_state     = S_SCAN;
                            end
                        end
                        OP_READ: begin
                            if (w_in_store) begin
                                n_res_valid = 1'b0;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_raddr = w_addr_rc;
                if (w_hit) begin
                    n_res_valid       = 1'b1;
                    n_res.found       = 1'b1;
                    n_res.edge_src    = VID_W'(r_prow);
                    n_res.edge_dst    = VID_W'(r_pcol);
                    n_res.edge_weight = i_rdata;
                    n_row             = r_prow;
                    n_col             = r_pcol + VW'(1);
                    n_state           = S_IDLE;
                end else if (w_exhausted) begin
                    n_res_valid = 1'b1;
                    n_active    = 1'b0;
                    n_kind      = 1'b0;
                    n_row       = '0;
                    n_col       = '0;
                    n_state     = S_IDLE;
                end else if (w_wrap) begin
                    n_row  = r_row + RW'(1);
                    n_col  = '0;
                    n_pend = 1'b0;
                end else begin
                    n_pend = 1'b1;
                    n_prow = r_row;
                    n_pcol = r_col;
                    n_col  = r_col + VW'(1);
                end
            end
            S_READ: begin
                n_res_valid       = 1'b1;
                n_res.edge_weight = i_rdata;
                n_state           = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_active    <= 1'b0;
            r_kind      <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_pend      <= 1'b0;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_kind      <= n_kind;
            r_row       <= n_row;
            r_col       <= n_col;
            r_pend      <= n_pend;
            r_clr       <= n_clr;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prow <= n_prow;
        r_pcol <= n_pcol;
        r_res  <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

FILE: hw/rtl/amesc_checker.sv
`include "adjacency_matrix_edge_scanner_core_assert.svh"

module amesc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_start,
    input logic                               o_busy,
    input logic [amesc_pkg::OP_W-1:0]         i_op,
    input logic                               o_valid,
    input logic                               o_found,
    input logic signed [amesc_pkg::WGT_W-1:0] o_edge_weight,
    input logic                               o_ignored
);

    import amesc_pkg::*;

    logic w_accept;
    logic w_quick_op;

    assign w_accept   = i_start && !o_busy;
    assign w_quick_op = (i_op == OP_SET) || (i_op == OP_REMOVE) ||
                        (i_op == OP_SCAN_ALL) || (i_op == OP_SCAN_SRC);

    `AMESC_ASSERT(a_beat_has_cause, i_clk, i_rst_n, o_valid |-> ($past(w_accept) || $past(o_busy)))
    `AMESC_ASSERT(a_quick_op_beat, i_clk, i_rst_n, (w_accept && w_quick_op) |=> (o_valid && !o_busy))
    `AMESC_ASSERT(a_ignored_clean, i_clk, i_rst_n, (o_valid && o_ignored) |-> (!o_found && o_edge_weight == 0))
    `AMESC_ASSERT(a_found_nonzero, i_clk, i_rst_n, (o_valid && o_found) |-> (o_edge_weight != 0))

endmodule

bind adjacency_matrix_edge_scanner_core amesc_checker u_amesc_checker (.*);
